// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int OCC_W        = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic        [TAG_W-1:0] tag_t;
    typedef logic        [OCC_W-1:0] occ_t;

    typedef struct packed {
        key_t key;
        tag_t tag;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } cmd_t;

    // what a cell hands to its neighbours: less flag and entry to the right, entry to the left
    typedef struct packed {
        logic   less;
        entry_t entry;
    } link_t;

endpackage

// ===== sv/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// valid/ready channels for request and result words
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    key_t entry_key;
    tag_t entry_tag;

    modport source (output valid, output kind, output entry_key, output entry_tag,
                    input ready);
    modport sink   (input valid, input kind, input entry_key, input entry_tag,
                    output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    logic head_valid;
    key_t head_key;
    tag_t head_tag;
    logic refused;
    occ_t occupancy;

    modport source (output valid, output head_valid, output head_key, output head_tag,
                    output refused, output occupancy, input ready);
    modport sink   (input valid, input head_valid, input head_key, input head_tag,
                    input refused, input occupancy, output ready);
endinterface

// ===== sv/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue, largest key first, built as a systolic sorted array
//
// Entries live in a row of CAPACITY cells kept in descending key order, cell 0
// holding the head. Every request word is either an insert (signed key plus
// tag) or a remove of the head, and each gives exactly one result word with
// the removed entry (if any), a refused flag for an insert into a full queue
// and the occupancy after the operation. Equal keys leave in arrival order.
// The queue takes one word per cycle: the new key is broadcast to all cells,
// each cell compares it with its own key and takes either its left
// neighbour's entry, the new entry or its right neighbour's entry, so the
// cycle is set by one 32-bit signed compare plus a three-way select per cell.
// A result sits in an output register and the next request is still taken
// while it waits, as long as the result is taken in the same cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // occupancy counter
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // output register
    logic   rsp_valid_reg;
    logic   head_valid_reg;
    entry_t head_reg;
    logic   refused_reg;
    occ_t   occ_reg;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          do_insert;
    logic          do_remove;
    logic          do_refuse;
    cmd_t          cmd;
    logic [CAPACITY-1:0] occupied;
    link_t         link [CAPACITY];

    // take a new word when the result slot is free or being emptied
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    assign do_insert = accept && (req.kind == OP_INSERT) && !is_full;
    assign do_refuse = accept && (req.kind == OP_INSERT) && is_full;
    assign do_remove = accept && (req.kind == OP_REMOVE) && !is_empty;

    assign cmd.insert    = do_insert;
    assign cmd.remove    = do_remove;
    assign cmd.entry.key = req.entry_key;
    assign cmd.entry.tag = req.entry_tag;

    // the row of cells; cell 0 is the head, an edge cell sees a neutral link
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            link_t  prev_link;
            entry_t next_ent;

            assign occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign prev_link = '0;
            end
            else
            begin : g_inner
                assign prev_link = link[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_ent = link[i].entry;
            end
            else
            begin : g_body
                assign next_ent = link[i+1].entry;
            end

            spq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occupied[i]),
                .prev       (prev_link),
                .next_entry (next_ent),
                .link       (link[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_valid_reg <= do_remove;
            head_reg       <= do_remove ? link[0].entry : '0;
            refused_reg    <= do_refuse;
            occ_reg        <= OCC_W'(count_next);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.head_valid = head_valid_reg;
    assign rsp.head_key   = head_reg.key;
    assign rsp.head_tag   = head_reg.tag;
    assign rsp.refused    = refused_reg;
    assign rsp.occupancy  = occ_reg;

    // checks
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_refuse_hold : assert property (@(posedge clk) disable iff (!rst_n)
        do_refuse |=> $stable(count_reg))
        else $error("refused insert changed occupancy");

    a_insert_inc : assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_remove_dec : assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink the queue");

    a_result_excl : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(head_valid_reg && refused_reg))
        else $error("result both removed and refused");

endmodule

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted array: holds an entry, shifts right on insert,
// left on remove
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic           clk,
    input  spq_pkg::cmd_t  cmd,
    input  logic           occupied,
    input  spq_pkg::link_t prev,
    input  spq_pkg::entry_t next_entry,
    output spq_pkg::link_t link
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   less;

    // empty slot counts as smaller than anything
    assign less = !occupied || (entry_reg.key < cmd.entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && less)
        begin
            entry_next = prev.less ? prev.entry : cmd.entry;
        end
        else if (cmd.remove)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.less  = less;
    assign link.entry = entry_reg;

endmodule
